>>> rtl/core/colour_opponent_channel_split_macros.svh
// assertion macros shared by the colour opponent channel split rtl
// expects signals named clock and reset in the including module
`ifndef COLOUR_OPPONENT_CHANNEL_SPLIT_MACROS_SVH
`define COLOUR_OPPONENT_CHANNEL_SPLIT_MACROS_SVH

// same-cycle implication
`define COP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication after a fixed number of cycles
`define COP_ASSERT_AFTER(lbl, ante, dly, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##(dly) (cons)) \
      else $error(msg);

`endif

>>> rtl/core/cop_pkg.sv
// shared types and constants for the colour opponent channel split
// no dependencies
`default_nettype none

package cop_pkg;

   localparam int unsigned PIX_W    = 8;
   localparam int unsigned LANES    = 4;
   localparam int unsigned QUO_BITS = 9;   // bit 8 flags a quotient above 255
   localparam int unsigned REM_W    = 15;  // 85 * 255 fits
   localparam int unsigned SUM_W    = 23;
   localparam int unsigned LUM_LSB  = 14;
   localparam int unsigned LATENCY  = QUO_BITS + 2;

   localparam logic [SUM_W-1:0] W_RED   = 23'd4899;
   localparam logic [SUM_W-1:0] W_GREEN = 23'd9617;
   localparam logic [SUM_W-1:0] W_BLUE  = 23'd1868;
   localparam logic [SUM_W-1:0] W_ROUND = 23'd8192;
   localparam logic [REM_W-1:0] GAIN    = 15'd85;
   localparam logic [PIX_W-1:0] MAX_LUM_RESET = 8'd255;

   localparam int unsigned LANE_RED    = 0;
   localparam int unsigned LANE_GREEN  = 1;
   localparam int unsigned LANE_BLUE   = 2;
   localparam int unsigned LANE_YELLOW = 3;

   typedef struct packed {
      logic                                valid;
      logic                                bright;
      logic [PIX_W-1:0]                    lum;
      logic [LANES-1:0][REM_W-1:0]         rem;
      logic [LANES-1:0][QUO_BITS-1:0]      quo;
   } cop_stage_type;

endpackage

`default_nettype wire

>>> rtl/core/cop_front.sv
// front stage: gray level, threshold test and scaled opponent numerators
// depends on cop_pkg
`default_nettype none

module cop_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [cop_pkg::PIX_W-1:0]   blue,
   input  wire logic [cop_pkg::PIX_W-1:0]   green,
   input  wire logic [cop_pkg::PIX_W-1:0]   red,
   input  wire logic [cop_pkg::PIX_W-1:0]   max_lum,
   output cop_pkg::cop_stage_type           stage_out
);

   logic [cop_pkg::SUM_W-1:0]  wsum;
   logic [cop_pkg::PIX_W-1:0]  lum;
   logic [11:0]                lum_x10;
   logic signed [10:0]         r_s, g_s, b_s;
   logic signed [10:0]         half_gb, half_rb, half_rg, diff_rg;
   logic signed [10:0]         num [cop_pkg::LANES];
   cop_pkg::cop_stage_type     stage_in;
   logic                       valid_ff;
   cop_pkg::cop_stage_type     data_ff;

   always_comb begin
      wsum = cop_pkg::SUM_W'(red)   * cop_pkg::W_RED
           + cop_pkg::SUM_W'(green) * cop_pkg::W_GREEN
           + cop_pkg::SUM_W'(blue)  * cop_pkg::W_BLUE
           + cop_pkg::W_ROUND;
      lum     = wsum[cop_pkg::LUM_LSB +: cop_pkg::PIX_W];
      lum_x10 = {1'b0, lum, 3'b000} + {3'b000, lum, 1'b0};

      r_s = signed'({3'b000, red});
      g_s = signed'({3'b000, green});
      b_s = signed'({3'b000, blue});
      // all sums are non-negative so the shift truncates like the halving
      half_gb = (g_s + b_s) >>> 1;
      half_rb = (r_s + b_s) >>> 1;
      half_rg = (r_s + g_s) >>> 1;
      diff_rg = (r_s >= g_s) ? (r_s - g_s) : (g_s - r_s);

      num[cop_pkg::LANE_RED]    = r_s - half_gb;
      num[cop_pkg::LANE_GREEN]  = g_s - half_rb;
      num[cop_pkg::LANE_BLUE]   = b_s - half_rg;
      num[cop_pkg::LANE_YELLOW] = half_rg - b_s - diff_rg;

      stage_in        = '0;
      stage_in.valid  = accept;
      stage_in.bright = lum_x10 > {4'b0000, max_lum};
      stage_in.lum    = lum;
      for (int i = 0; i < cop_pkg::LANES; i++) begin
         // negative numerators clamp to zero, positive ones stay below 256
         stage_in.rem[i] = num[i][10] ? '0 :
            cop_pkg::REM_W'(cop_pkg::REM_W'(num[i][7:0]) * cop_pkg::GAIN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= stage_in;
   end

   always_comb begin
      stage_out       = data_ff;
      stage_out.valid = valid_ff;
   end

endmodule

`default_nettype wire

>>> rtl/core/cop_div_cell.sv
// one restoring divide cell: resolves one quotient bit on all four lanes
// depends on cop_pkg
`default_nettype none

module cop_div_cell #(
   parameter int unsigned BIT = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cop_pkg::cop_stage_type stage_in,
   output cop_pkg::cop_stage_type      stage_out
);

   localparam int unsigned CMP_W = cop_pkg::PIX_W + cop_pkg::QUO_BITS;

   logic [CMP_W-1:0]          den_sh;
   logic [CMP_W-1:0]          rem_ext;
   cop_pkg::cop_stage_type    next_in;
   logic                      valid_ff;
   cop_pkg::cop_stage_type    data_ff;

   always_comb begin
      den_sh  = CMP_W'(stage_in.lum) << BIT;
      next_in = stage_in;
      rem_ext = '0;
      for (int i = 0; i < cop_pkg::LANES; i++) begin
         rem_ext = CMP_W'(stage_in.rem[i]);
         if (rem_ext >= den_sh) begin
            next_in.rem[i]      = cop_pkg::REM_W'(rem_ext - den_sh);
            next_in.quo[i][BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= next_in;
   end

   always_comb begin
      stage_out       = data_ff;
      stage_out.valid = valid_ff;
   end

endmodule

`default_nettype wire

>>> rtl/core/cop_round.sv
// output stage: half-to-even rounding, saturation and dark-pixel gating
// depends on cop_pkg
`default_nettype none

module cop_round (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cop_pkg::cop_stage_type     stage_in,
   output logic                            rsp_valid,
   output logic [cop_pkg::PIX_W-1:0]       rsp_intensity,
   output logic [cop_pkg::PIX_W-1:0]       rsp_red_chan,
   output logic [cop_pkg::PIX_W-1:0]       rsp_green_chan,
   output logic [cop_pkg::PIX_W-1:0]       rsp_blue_chan,
   output logic [cop_pkg::PIX_W-1:0]       rsp_yellow_chan
);

   localparam int unsigned TOP = cop_pkg::QUO_BITS - 1;

   logic [cop_pkg::PIX_W:0]    twice_rem [cop_pkg::LANES];
   logic [cop_pkg::PIX_W:0]    den;
   logic [cop_pkg::PIX_W-1:0]  quo [cop_pkg::LANES];
   logic                       up  [cop_pkg::LANES];
   logic [cop_pkg::PIX_W-1:0]  chan_in [cop_pkg::LANES];
   logic                       valid_ff;
   logic [cop_pkg::PIX_W-1:0]  lum_ff;
   logic [cop_pkg::PIX_W-1:0]  chan_ff [cop_pkg::LANES];

   always_comb begin
      den = {1'b0, stage_in.lum};
      for (int i = 0; i < cop_pkg::LANES; i++) begin
         quo[i] = stage_in.quo[i][cop_pkg::PIX_W-1:0];
         // without overflow the remainder is below the divisor, so 8 bits hold it
         twice_rem[i] = {stage_in.rem[i][cop_pkg::PIX_W-1:0], 1'b0};
         up[i] = (twice_rem[i] > den) || ((twice_rem[i] == den) && quo[i][0]);
         if (!stage_in.bright) begin
            chan_in[i] = '0;
         end else if (stage_in.quo[i][TOP] || (up[i] && (quo[i] == '1))) begin
            chan_in[i] = '1;
         end else begin
            chan_in[i] = quo[i] + cop_pkg::PIX_W'(up[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      lum_ff  <= stage_in.lum;
      chan_ff <= chan_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_intensity   = lum_ff;
   assign rsp_red_chan    = chan_ff[cop_pkg::LANE_RED];
   assign rsp_green_chan  = chan_ff[cop_pkg::LANE_GREEN];
   assign rsp_blue_chan   = chan_ff[cop_pkg::LANE_BLUE];
   assign rsp_yellow_chan = chan_ff[cop_pkg::LANE_YELLOW];

endmodule

`default_nettype wire

>>> rtl/core/colour_opponent_channel_split.sv
// top level of the colour opponent channel split
// depends on cop_pkg, cop_front, cop_div_cell, cop_round and the macro header
//
//   port group  direction  handshake         contents
//   req_        in         start / busy      blue, green, red words
//   rsp_        out        rsp_valid strobe  intensity and four opponent channels
//   csr_        in         csr_wr_en         max_luminance
//
// one word enters per clock; busy never rises
// each taken word passes through the front stage, nine divide cells
// (one quotient bit each, bit 8 flags saturation) and the rounding stage
// synchronous reset clears the valid chain and sets max_luminance to 255
// results are a one-cycle strobe; the receiver cannot stall them
`default_nettype none
`include "colour_opponent_channel_split_macros.svh"

module colour_opponent_channel_split (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic [cop_pkg::PIX_W-1:0]  req_blue,
   input  wire logic [cop_pkg::PIX_W-1:0]  req_green,
   input  wire logic [cop_pkg::PIX_W-1:0]  req_red,
   input  wire logic                       csr_wr_en,
   input  wire logic [cop_pkg::PIX_W-1:0]  csr_wr_data,
   output logic                            rsp_valid,
   output logic [cop_pkg::PIX_W-1:0]       rsp_intensity,
   output logic [cop_pkg::PIX_W-1:0]       rsp_red_chan,
   output logic [cop_pkg::PIX_W-1:0]       rsp_green_chan,
   output logic [cop_pkg::PIX_W-1:0]       rsp_blue_chan,
   output logic [cop_pkg::PIX_W-1:0]       rsp_yellow_chan
);

   logic [cop_pkg::PIX_W-1:0]  max_lum_ff;
   logic [cop_pkg::PIX_W-1:0]  max_lum_in;
   logic                       accept;
   cop_pkg::cop_stage_type     stage [cop_pkg::QUO_BITS+1];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign max_lum_in = csr_wr_en ? csr_wr_data : max_lum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_lum_ff <= cop_pkg::MAX_LUM_RESET;
      end else begin
         max_lum_ff <= max_lum_in;
      end
   end

   cop_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .blue      (req_blue),
      .green     (req_green),
      .red       (req_red),
      .max_lum   (max_lum_ff),
      .stage_out (stage[0])
   );

   // cell i resolves quotient bit 8 - i, so the chain works from the top down
   for (genvar i = 0; i < cop_pkg::QUO_BITS; i++) begin : g_cell
      cop_div_cell #(
         .BIT (cop_pkg::QUO_BITS - 1 - i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (stage[i]),
         .stage_out (stage[i+1])
      );
   end

   cop_round u_round (
      .clock           (clock),
      .reset           (reset),
      .stage_in        (stage[cop_pkg::QUO_BITS]),
      .rsp_valid       (rsp_valid),
      .rsp_intensity   (rsp_intensity),
      .rsp_red_chan    (rsp_red_chan),
      .rsp_green_chan  (rsp_green_chan),
      .rsp_blue_chan   (rsp_blue_chan),
      .rsp_yellow_chan (rsp_yellow_chan)
   );

   `COP_ASSERT_AFTER(a_word_leaves, accept, cop_pkg::LATENCY, rsp_valid, "accepted word lost")
   `COP_ASSERT_IMPLIES(a_no_phantom, rsp_valid, $past(accept, cop_pkg::LATENCY), "result without word")
   `COP_ASSERT_IMPLIES(a_black_dark, rsp_valid && (rsp_intensity == '0), (rsp_red_chan == '0) && (rsp_green_chan == '0) && (rsp_blue_chan == '0) && (rsp_yellow_chan == '0), "black pixel with nonzero channel")

endmodule

`default_nettype wire
